// ----- src/hk3_pkg.sv -----
// Shared types, constants and orientation tables for the 3-D Hilbert key core.
package hk3_pkg;

    localparam int MAX_BITS   = 21;
    localparam int COORD_W    = 21;
    localparam int KEY_W      = 63;
    localparam int CFG_W      = 5;
    localparam int ORIENT_W   = 5;
    localparam int NUM_ORIENT = 24;
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 64;

    localparam logic [CFG_W-1:0] KEY_BITS_RESET = CFG_W'(21);
    localparam logic [CFG_W-1:0] KEY_BITS_MAX   = CFG_W'(MAX_BITS);

    typedef logic [COORD_W-1:0]  coord_t;
    typedef logic [KEY_W-1:0]    key_t;
    typedef logic [ORIENT_W-1:0] orient_t;
    typedef logic [2:0]          octant_t;

    // Payload carried from cell to cell
    typedef struct packed {
        coord_t  coord_x;
        coord_t  coord_y;
        coord_t  coord_z;
        orient_t orient;
        logic    reversed;
        key_t    key;
    } hk3_stage_t;

    // Per-cell control from the top level
    typedef struct packed {
        logic           advance;
        logic           active;
        logic [4:0]     bit_idx;
    } hk3_ctrl_t;

    // Octant by orientation, indexed by {bx, by, bz}
    localparam octant_t OCTANT_OF [NUM_ORIENT][8] = '{
        '{3'd0, 3'd7, 3'd1, 3'd6, 3'd3, 3'd4, 3'd2, 3'd5},
        '{3'd7, 3'd4, 3'd6, 3'd5, 3'd0, 3'd3, 3'd1, 3'd2},
        '{3'd4, 3'd3, 3'd5, 3'd2, 3'd7, 3'd0, 3'd6, 3'd1},
        '{3'd3, 3'd0, 3'd2, 3'd1, 3'd4, 3'd7, 3'd5, 3'd6},
        '{3'd1, 3'd0, 3'd6, 3'd7, 3'd2, 3'd3, 3'd5, 3'd4},
        '{3'd0, 3'd3, 3'd7, 3'd4, 3'd1, 3'd2, 3'd6, 3'd5},
        '{3'd3, 3'd2, 3'd4, 3'd5, 3'd0, 3'd1, 3'd7, 3'd6},
        '{3'd2, 3'd1, 3'd5, 3'd6, 3'd3, 3'd0, 3'd4, 3'd7},
        '{3'd6, 3'd1, 3'd7, 3'd0, 3'd5, 3'd2, 3'd4, 3'd3},
        '{3'd1, 3'd2, 3'd0, 3'd3, 3'd6, 3'd5, 3'd7, 3'd4},
        '{3'd2, 3'd5, 3'd3, 3'd4, 3'd1, 3'd6, 3'd0, 3'd7},
        '{3'd5, 3'd6, 3'd4, 3'd7, 3'd2, 3'd1, 3'd3, 3'd0},
        '{3'd7, 3'd6, 3'd0, 3'd1, 3'd4, 3'd5, 3'd3, 3'd2},
        '{3'd6, 3'd5, 3'd1, 3'd2, 3'd7, 3'd4, 3'd0, 3'd3},
        '{3'd5, 3'd4, 3'd2, 3'd3, 3'd6, 3'd7, 3'd1, 3'd0},
        '{3'd4, 3'd7, 3'd3, 3'd0, 3'd5, 3'd6, 3'd2, 3'd1},
        '{3'd6, 3'd7, 3'd5, 3'd4, 3'd1, 3'd0, 3'd2, 3'd3},
        '{3'd7, 3'd0, 3'd4, 3'd3, 3'd6, 3'd1, 3'd5, 3'd2},
        '{3'd0, 3'd1, 3'd3, 3'd2, 3'd7, 3'd6, 3'd4, 3'd5},
        '{3'd1, 3'd6, 3'd2, 3'd5, 3'd0, 3'd7, 3'd3, 3'd4},
        '{3'd2, 3'd3, 3'd1, 3'd0, 3'd5, 3'd4, 3'd6, 3'd7},
        '{3'd3, 3'd4, 3'd0, 3'd7, 3'd2, 3'd5, 3'd1, 3'd6},
        '{3'd4, 3'd5, 3'd7, 3'd6, 3'd3, 3'd2, 3'd0, 3'd1},
        '{3'd5, 3'd2, 3'd6, 3'd1, 3'd4, 3'd3, 3'd7, 3'd0}
    };

    localparam orient_t NEXT_X [NUM_ORIENT] = '{
        5'd4,  5'd5,  5'd6,  5'd7,  5'd8,  5'd9,  5'd10, 5'd11,
        5'd12, 5'd13, 5'd14, 5'd15, 5'd0,  5'd1,  5'd2,  5'd3,
        5'd17, 5'd18, 5'd19, 5'd16, 5'd23, 5'd20, 5'd21, 5'd22
    };

    localparam orient_t NEXT_Y [NUM_ORIENT] = '{
        5'd1,  5'd2,  5'd3,  5'd0,  5'd16, 5'd17, 5'd18, 5'd19,
        5'd11, 5'd8,  5'd9,  5'd10, 5'd22, 5'd23, 5'd20, 5'd21,
        5'd14, 5'd15, 5'd12, 5'd13, 5'd4,  5'd5,  5'd6,  5'd7
    };

    localparam logic [1:0] TURNS_X [8] = '{2'd3, 2'd0, 2'd0, 2'd2, 2'd2, 2'd0, 2'd0, 2'd1};
    localparam logic [1:0] TURNS_Y [8] = '{2'd0, 2'd1, 2'd1, 2'd2, 2'd2, 2'd3, 2'd3, 2'd0};
    localparam logic       SENSE_FLIP [8] = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1};

    // Octant lookup; orientation codes past the table map to zero
    function automatic octant_t octant_lookup(input orient_t orient, input logic [2:0] sel);
        octant_t oct;
        oct = '0;
        if (orient < ORIENT_W'(NUM_ORIENT)) begin
            oct = OCTANT_OF[orient][sel];
        end
        return oct;
    endfunction

    // Apply x-rotations then y-rotations for the given octant
    function automatic orient_t orient_advance(input orient_t orient, input octant_t oct);
        orient_t o;
        o = orient;
        for (int t = 0; t < 3; t++) begin
            if (2'(t) < TURNS_X[oct] && o < ORIENT_W'(NUM_ORIENT)) begin
                o = NEXT_X[o];
            end
        end
        for (int t = 0; t < 3; t++) begin
            if (2'(t) < TURNS_Y[oct] && o < ORIENT_W'(NUM_ORIENT)) begin
                o = NEXT_Y[o];
            end
        end
        return o;
    endfunction

endpackage

// ----- src/hilbert_key_3d_core.sv -----
// Top level of the 3-D Peano-Hilbert key core: config register and cell chain.
//
// Usage:
//   Input stream s_*: one coordinate triple per transaction. Output stream m_*:
//   one 63-bit key per transaction, in input order.
//   Config channel cfg_*: writes key_bits (levels per axis, values above 21
//   act as 21, zero yields a zero key). Always ready; write only while idle.
//   Each of the 21 cells in the chain handles one fixed coordinate bit, from
//   bit 20 down to bit 0, and passes through unchanged at or above the level count.
//   Output path: each cell registers the item in turn; the last cell's
//   register is the output register.
//   Throughput: one item per cycle while the output is not stalled; the chain
//   is a single shift line that moves one cell on each advance.
//   Back-pressure: when m_tvalid is high and m_tready low, the whole chain
//   holds and s_tready drops; any free output slot lets the chain advance.
//   Reset: all cells are emptied and key_bits returns to 21.
module hilbert_key_3d_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Config write
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [hk3_pkg::CFG_W-1:0]           cfg_data,
    // Input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [hk3_pkg::IN_TDATA_W-1:0]      s_tdata,  // coord_x[20:0], coord_y[41:21], coord_z[62:42], pad
    // Output stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [hk3_pkg::OUT_TDATA_W-1:0]     m_tdata   // hilbert_key[62:0], pad
);
    import hk3_pkg::*;

    logic [CFG_W-1:0] key_bits_reg;
    logic [CFG_W-1:0] levels;
    logic             advance;
    hk3_stage_t       head;
    logic       valid_chain [MAX_BITS+1];
    hk3_stage_t stage_chain [MAX_BITS+1];

    // Hold config register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_bits_reg <= KEY_BITS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            key_bits_reg <= cfg_data;
        end
    end
    assign cfg_ready = 1'b1;

    // Saturate level count
    assign levels = (key_bits_reg > KEY_BITS_MAX) ? KEY_BITS_MAX : key_bits_reg;

    // Advance the chain whenever the output slot is free
    assign advance  = m_tready || !m_tvalid;
    assign s_tready = advance;

    // Unpack the input transaction into the chain head
    always_comb begin
        head.coord_x  = s_tdata[COORD_W-1:0];
        head.coord_y  = s_tdata[2*COORD_W-1:COORD_W];
        head.coord_z  = s_tdata[3*COORD_W-1:2*COORD_W];
        head.orient   = '0;
        head.reversed = 1'b0;
        head.key      = '0;
    end

    assign valid_chain[0] = s_tvalid;
    assign stage_chain[0] = head;

    // Build the cell chain, most significant bit first
    for (genvar k = 0; k < MAX_BITS; k++) begin : g_cell
        hk3_ctrl_t ctrl;
        always_comb begin
            ctrl.advance = advance;
            ctrl.bit_idx = 5'(MAX_BITS - 1 - k);
            ctrl.active  = ctrl.bit_idx < levels;
        end
        hk3_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl),
            .valid_in  (valid_chain[k]),
            .stage_in  (stage_chain[k]),
            .valid_out (valid_chain[k+1]),
            .stage_out (stage_chain[k+1])
        );
    end

    assign m_tvalid = valid_chain[MAX_BITS];
    assign m_tdata  = {{(OUT_TDATA_W-KEY_W){1'b0}}, stage_chain[MAX_BITS].key};

    // Accepted input enters the first cell
    a_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> valid_chain[1])
        else $error("accepted item did not enter first cell");

    // Stall freezes the last cells
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(valid_chain[MAX_BITS-1]) && $stable(stage_chain[MAX_BITS].key))
        else $error("chain moved while stalled");

    // Zero levels give a zero key
    a_zero_levels: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && key_bits_reg == '0 |-> m_tdata == '0)
        else $error("nonzero key with zero levels");

    // Ready follows the output slot
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input accepted while output blocked");

endmodule

// ----- src/hk3_cell.sv -----
// One level cell: consumes one coordinate bit triple and, when active, appends one key digit.
module hk3_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  hk3_pkg::hk3_ctrl_t ctrl,
    input  logic               valid_in,
    input  hk3_pkg::hk3_stage_t stage_in,
    output logic               valid_out,
    output hk3_pkg::hk3_stage_t stage_out
);
    import hk3_pkg::*;

    logic       valid_reg;
    hk3_stage_t stage_reg;
    hk3_stage_t stage_next;
    logic [2:0] sel;
    octant_t    oct;
    octant_t    digit;

    // Compute this level's digit, sense and orientation
    always_comb begin
        sel   = {stage_in.coord_x[ctrl.bit_idx], stage_in.coord_y[ctrl.bit_idx],
                 stage_in.coord_z[ctrl.bit_idx]};
        oct   = octant_lookup(stage_in.orient, sel);
        digit = stage_in.reversed ? (3'd7 - oct) : oct;
        stage_next = stage_in;
        if (ctrl.active) begin
            stage_next.key      = {stage_in.key[KEY_W-4:0], digit};
            stage_next.reversed = stage_in.reversed ^ SENSE_FLIP[oct];
            stage_next.orient   = orient_advance(stage_in.orient, oct);
        end
    end

    // Advance valid flag with the pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ctrl.advance) begin
            valid_reg <= valid_in;
        end
    end

    // Hold payload while stalled
    always_ff @(posedge aclk) begin
        if (ctrl.advance) begin
            stage_reg <= stage_next;
        end
    end

    assign valid_out = valid_reg;
    assign stage_out = stage_reg;

endmodule
